// ===== rtl/core/dual_crc32_path_hash_core_assert.svh =====
// Assertion macros for the dual CRC path hash RTL, used by the back stage.
`ifndef DUAL_CRC32_PATH_HASH_CORE_ASSERT_SVH
`define DUAL_CRC32_PATH_HASH_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DCPH_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCPH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/dcph_pkg.sv =====
// Shared types and constants for the dual CRC path hash core.
`timescale 1ns / 1ps
`default_nettype none

package dcph_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [CrcW-1:0] FirstPolyReset  = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] SecondPolyReset = 32'h1247_7CDF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFirstPoly  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondPoly = 8'd1;

  // One classified request between front and back.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } dcph_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcph_front.sv =====
// Front stage: accepts input bytes, applies path folding, registers the request.
`timescale 1ns / 1ps
`default_nettype none

module dcph_front import dcph_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_data_i,
  input  wire logic             in_fold_i,
  input  wire logic             in_last_i,
  output logic                  req_valid_o,
  input  wire logic             req_ready_i,
  output dcph_req_t             req_o
);

  localparam logic [ByteW-1:0] LowA      = 8'h61;
  localparam logic [ByteW-1:0] LowZ      = 8'h7A;
  localparam logic [ByteW-1:0] BackSlash = 8'h5C;
  localparam logic [ByteW-1:0] Slash     = 8'h2F;
  localparam logic [ByteW-1:0] CaseBit   = 8'h20;

  logic      valid_q, valid_d;
  dcph_req_t req_q, req_d;
  logic      take;
  logic [ByteW-1:0] folded;

  always_comb begin
    folded = in_data_i;
    if (in_fold_i) begin
      if (in_data_i inside {[LowA:LowZ]}) begin
        folded = in_data_i & ~CaseBit;
      end else if (in_data_i == BackSlash) begin
        folded = Slash;
      end
    end
  end

  assign in_ready_o = !valid_q || req_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (take) begin
      valid_d    = 1'b1;
      req_d.data = folded;
      req_d.last = in_last_i;
    end else if (req_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

// ===== rtl/core/dcph_queue.sv =====
// Small request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module dcph_queue import dcph_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire dcph_req_t push_req_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output dcph_req_t      pop_req_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dcph_req_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dcph_back.sv =====
// Back stage: two reflected CRC-32 engines and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dcph_back import dcph_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CrcW-1:0]   first_poly_i,
  input  wire logic [CrcW-1:0]   second_poly_i,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire dcph_req_t         req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2*CrcW-1:0]      out_data_o
);

  // Eight bit-serial shift steps of a reflected CRC.
  function automatic logic [CrcW-1:0] crc_step8(input logic [CrcW-1:0] crc,
                                                input logic [CrcW-1:0] poly,
                                                input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  logic [CrcW-1:0]   first_crc_q, first_crc_d;
  logic [CrcW-1:0]   second_crc_q, second_crc_d;
  logic [CrcW-1:0]   first_next, second_next;
  logic              out_valid_q, out_valid_d;
  logic [2*CrcW-1:0] out_data_q, out_data_d;
  logic              out_free, pop, pop_last;

  assign out_free    = !out_valid_q || out_ready_i;
  // Plain bytes always drain; a final byte waits for a free result slot.
  assign req_ready_o = !req_i.last || out_free;
  assign pop         = req_valid_i && req_ready_o;
  assign pop_last    = pop && req_i.last;

  assign first_next  = crc_step8(first_crc_q, first_poly_i, req_i.data);
  assign second_next = crc_step8(second_crc_q, second_poly_i, req_i.data);

  always_comb begin
    first_crc_d  = first_crc_q;
    second_crc_d = second_crc_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      if (req_i.last) begin
        out_valid_d  = 1'b1;
        out_data_d   = {first_next, second_next};
        first_crc_d  = '0;
        second_crc_d = '0;
      end else begin
        first_crc_d  = first_next;
        second_crc_d = second_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_crc_q  <= '0;
      second_crc_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      first_crc_q  <= first_crc_d;
      second_crc_q <= second_crc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "dual_crc32_path_hash_core_assert.svh"

  `DCPH_ASSERT_NEXT(a_last_sets_result, pop_last, out_valid_q, "final byte gave no result")
  `DCPH_ASSERT_NEXT(a_last_clears_crc, pop_last, (first_crc_q | second_crc_q) == '0, "CRC kept")
  `DCPH_ASSERT_IMPL(a_result_from_last, $rose(out_valid_q), $past(pop_last), "stray result")

endmodule

`default_nettype wire

// ===== rtl/core/dual_crc32_path_hash_core.sv =====
// Top level of the dual CRC path hash: config registers, front, queue, back.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata=data_byte, tuser=fold_path,
//           |           |                              | tlast=last_byte
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata=crc_pair (first CRC high)
//  cfg      | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// Throughput is one byte per cycle while no final byte waits on an m_axis stall;
// the combinational eight-step CRC update in the back stage sets that figure.
// A final byte's result reaches m_axis through the front register, which loads
// on the accepting edge, then a queue slot, then the result register.
// Reset clears both CRCs and loads the default polynomials; no clearing pass.
// m_axis stalls hold only final bytes; plain bytes ahead of a held final byte keep draining, those behind it wait.
// Config writes are always taken (cfg_ready_o tied high); unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module dual_crc32_path_hash_core import dcph_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input byte stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [ByteW-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  wire logic               s_axis_tuser,  // [0] fold_path
  input  wire logic               s_axis_tlast,
  // result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [2*CrcW-1:0]       m_axis_tdata,  // [63:0] crc_pair
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CrcW-1:0]    cfg_data_i
);

  logic [CrcW-1:0] first_poly_q, first_poly_d;
  logic [CrcW-1:0] second_poly_q, second_poly_d;
  logic            cfg_we;

  logic      fr_valid, fr_ready;
  dcph_req_t fr_req;
  logic      bk_valid, bk_ready;
  dcph_req_t bk_req;

  // Polynomial registers; the host writes them only while the datapath is idle (not enforced by the block).
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    first_poly_d  = first_poly_q;
    second_poly_d = second_poly_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CfgFirstPoly:  first_poly_d  = cfg_data_i;
        CfgSecondPoly: second_poly_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_poly_q  <= FirstPolyReset;
      second_poly_q <= SecondPolyReset;
    end else begin
      first_poly_q  <= first_poly_d;
      second_poly_q <= second_poly_d;
    end
  end

  // Front: take the byte and fold it when fold_path is set.
  dcph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_fold_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .req_valid_o (fr_valid),
    .req_ready_i (fr_ready),
    .req_o       (fr_req)
  );

  // Decoupling queue.
  dcph_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_req_i   (fr_req),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_req_o    (bk_req)
  );

  // Back: CRC engines and result register.
  dcph_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .first_poly_i  (first_poly_q),
    .second_poly_i (second_poly_q),
    .req_valid_i   (bk_valid),
    .req_ready_o   (bk_ready),
    .req_i         (bk_req),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire
